/* rtl/core/umpd_pkg.sv */
// ----------------------------------------------------------------------------
// USB MIDI packet decoder package
// Shared codes for the event packet decoder: code index values, status
// types and the message class encoding.
// ----------------------------------------------------------------------------
package umpd_pkg;

  // Code index numbers (low nibble of the packet header).
  localparam logic [3:0] CinSysCommon2 = 4'h2;
  localparam logic [3:0] CinSysCommon3 = 4'h3;
  localparam logic [3:0] CinSysExFirst = 4'h4;
  localparam logic [3:0] CinSysExLast  = 4'h7;
  localparam logic [3:0] CinNoteOff    = 4'h8;
  localparam logic [3:0] CinNoteOn     = 4'h9;
  localparam logic [3:0] CinCtrlChange = 4'hB;
  localparam logic [3:0] CinSingleByte = 4'hF;

  // Status types (high nibble of the status byte).
  localparam logic [3:0] StNoteOff     = 4'h8;
  localparam logic [3:0] StNoteOn      = 4'h9;
  localparam logic [3:0] StPolyPress   = 4'hA;
  localparam logic [3:0] StCtrlChange  = 4'hB;
  localparam logic [3:0] StProgChange  = 4'hC;
  localparam logic [3:0] StChanPress   = 4'hD;
  localparam logic [3:0] StPitchBend   = 4'hE;
  localparam logic [3:0] StSystem      = 4'hF;

  // Controllers that count as a panic request.
  localparam logic [7:0] CtlAllSoundOff   = 8'd120;
  localparam logic [7:0] CtlResetAllCtl   = 8'd121;
  localparam logic [7:0] CtlAllNotesOff   = 8'd123;

  typedef enum logic [3:0] {
    MC_NOTE_OFF    = 4'd0,
    MC_NOTE_ON     = 4'd1,
    MC_POLY_PRESS  = 4'd2,
    MC_CTRL_CHANGE = 4'd3,
    MC_PROG_CHANGE = 4'd4,
    MC_CHAN_PRESS  = 4'd5,
    MC_PITCH_BEND  = 4'd6,
    MC_SYSEX       = 4'd7,
    MC_SYS_COMMON  = 4'd8,
    MC_REALTIME    = 4'd9,
    MC_UNKNOWN     = 4'd10
  } msg_class_e;

endpackage

/* rtl/core/umpd_if.sv */
// ----------------------------------------------------------------------------
// USB MIDI packet decoder channels
// Valid/ready channels for raw event packets and for decoded results.
// ----------------------------------------------------------------------------
interface umpd_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;

  modport source (output valid, header_byte, status_byte, first_data, second_data,
                  input ready);
  modport sink   (input valid, header_byte, status_byte, first_data, second_data,
                  output ready);
endinterface

interface umpd_res_if;
  logic        valid;
  logic        ready;
  logic        note_valid;
  logic        note_on;
  logic [3:0]  channel;
  logic [7:0]  note_number;
  logic [7:0]  velocity;
  logic        panic;
  logic [3:0]  message_class;
  logic [3:0]  cable_number;
  logic [3:0]  code_index;
  logic [14:0] combined_value;

  modport source (output valid, note_valid, note_on, channel, note_number, velocity,
                         panic, message_class, cable_number, code_index,
                         combined_value,
                  input ready);
  modport sink   (input valid, note_valid, note_on, channel, note_number, velocity,
                        panic, message_class, cable_number, code_index,
                        combined_value,
                  output ready);
endinterface

/* rtl/core/usb_midi_packet_decoder_core.sv */
// ----------------------------------------------------------------------------
// USB MIDI event packet decoder
// Splits a four-byte event packet into cable, code index, note event, panic
// flag, message class and the 15-bit combined data value.
// ----------------------------------------------------------------------------
// The decoder takes one packet per clock cycle while the result side keeps
// ready high and returns one result item for every packet, in order. A packet
// is captured in an input register, decoded by a single level of compare
// logic and held in a result register, which offers it on the result side;
// the throughput is one item per cycle for as long as the result side keeps
// ready high. The input register is loaded whenever it is empty or the
// result register is empty or being drained, so while a finished result
// waits to be taken the input register still accepts a packet if it is
// empty, and then the input side stalls until the result is taken.
module usb_midi_packet_decoder_core (
  input logic      clk_i,
  input logic      rst_ni,
  umpd_pkt_if.sink   in_i,
  umpd_res_if.source out_o
);
  import umpd_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] sts_q, sts_d;
  logic [7:0] d1_q, d1_d;
  logic [7:0] d2_q, d2_d;

  // Result register.
  logic        res_vld_q;
  logic        note_valid_q, note_valid_d;
  logic        note_on_q, note_on_d;
  logic        panic_q, panic_d;
  msg_class_e  class_q, class_d;
  logic [14:0] comb_q, comb_d;
  logic [7:0]  res_hdr_q, res_sts_q, res_d1_q, res_d2_q;

  logic       res_take;
  logic       in_take;
  logic [3:0] cin;
  logic [3:0] kind;
  logic       is_panic_ctl;

  assign res_take = !res_vld_q || out_o.ready;
  assign in_take  = !in_vld_q || res_take;
  assign in_i.ready = in_take;

  assign hdr_d = in_i.header_byte;
  assign sts_d = in_i.status_byte;
  assign d1_d  = in_i.first_data;
  assign d2_d  = in_i.second_data;

  // Decode of the packet held in the input register.
  assign cin  = hdr_q[3:0];
  assign kind = sts_q[7:4];
  assign is_panic_ctl = (d1_q == CtlAllSoundOff) || (d1_q == CtlResetAllCtl) ||
                        (d1_q == CtlAllNotesOff);

  always_comb begin
    note_valid_d = 1'b0;
    note_on_d    = 1'b0;
    panic_d      = 1'b0;
    if (cin == CinCtrlChange && kind == StCtrlChange) begin
      panic_d = is_panic_ctl;
    end else if ((cin == CinNoteOff && kind == StNoteOff) ||
                 (cin == CinNoteOn && kind == StNoteOn)) begin
      note_valid_d = 1'b1;
      note_on_d    = (kind == StNoteOn) && (d2_q != 8'd0);
    end
  end

  always_comb begin
    case (kind)
      StNoteOff:    class_d = MC_NOTE_OFF;
      StNoteOn:     class_d = (d2_q == 8'd0) ? MC_NOTE_OFF : MC_NOTE_ON;
      StPolyPress:  class_d = MC_POLY_PRESS;
      StCtrlChange: class_d = MC_CTRL_CHANGE;
      StProgChange: class_d = MC_PROG_CHANGE;
      StChanPress:  class_d = MC_CHAN_PRESS;
      StPitchBend:  class_d = MC_PITCH_BEND;
      StSystem: begin
        // Real-time bytes are recognized by status alone; the rest of the
        // system range depends on the code index.
        if (sts_q[3]) begin
          class_d = MC_REALTIME;
        end else if (cin >= CinSysExFirst && cin <= CinSysExLast) begin
          class_d = MC_SYSEX;
        end else if (cin == CinSysCommon2 || cin == CinSysCommon3 ||
                     cin == CinSingleByte) begin
          class_d = MC_SYS_COMMON;
        end else begin
          class_d = MC_UNKNOWN;
        end
      end
      default:      class_d = MC_UNKNOWN;
    endcase
  end

  assign comb_d = {d2_q, 7'b0} | {7'b0, d1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= in_i.valid;
      end
      if (res_take) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hdr_q <= hdr_d;
      sts_q <= sts_d;
      d1_q  <= d1_d;
      d2_q  <= d2_d;
    end
    if (res_take) begin
      note_valid_q <= note_valid_d;
      note_on_q    <= note_on_d;
      panic_q      <= panic_d;
      class_q      <= class_d;
      comb_q       <= comb_d;
      res_hdr_q    <= hdr_q;
      res_sts_q    <= sts_q;
      res_d1_q     <= d1_q;
      res_d2_q     <= d2_q;
    end
  end

  assign out_o.valid          = res_vld_q;
  assign out_o.note_valid     = note_valid_q;
  assign out_o.note_on        = note_on_q;
  assign out_o.channel        = res_sts_q[3:0];
  assign out_o.note_number    = res_d1_q;
  assign out_o.velocity       = res_d2_q;
  assign out_o.panic          = panic_q;
  assign out_o.message_class  = class_q;
  assign out_o.cable_number   = res_hdr_q[7:4];
  assign out_o.code_index     = res_hdr_q[3:0];
  assign out_o.combined_value = comb_q;

endmodule
